/* design/rost_pkg.sv */
`timescale 1ns / 1ps

package rost_pkg;

  // A box has three axes; the cross-term test pairs each axis with the other two.
  localparam int unsigned NumAxes = 3;

  localparam int unsigned NextAxis [NumAxes] = '{1, 2, 0};
  localparam int unsigned PrevAxis [NumAxes] = '{2, 0, 1};

  // Register stages from an accepted item to its result strobe.
  localparam int unsigned PipeDepth = 8;

endpackage

/* design/ray_obb_separating_axis_test.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           dir_*_i, orig_*_i, box_center_i,
//                                                half_extents_i, axis_u/v/w_i
// result    out        done_o (one-cycle strobe) hit_o
//
// An item is taken at every clock edge where start_i is high and busy_o is low;
// busy_o stays low, so one ray-box pair can enter in every cycle.
// done_o comes from the valid bit of the last of the eight register stages of the
// pipeline, and hit_o is registered in that same stage.
// Reset clears only the valid bits that travel with the items.
// The receiver cannot stall, so no stage ever holds; items leave in order.
module ray_obb_separating_axis_test #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [COORD_BITS-1:0]   dir_x_i,
  input  logic signed [COORD_BITS-1:0]   dir_y_i,
  input  logic signed [COORD_BITS-1:0]   dir_z_i,
  input  logic signed [COORD_BITS-1:0]   orig_x_i,
  input  logic signed [COORD_BITS-1:0]   orig_y_i,
  input  logic signed [COORD_BITS-1:0]   orig_z_i,
  input  logic        [3*COORD_BITS-1:0] box_center_i,
  input  logic        [3*COORD_BITS-1:0] half_extents_i,
  input  logic        [3*COORD_BITS-1:0] axis_u_i,
  input  logic        [3*COORD_BITS-1:0] axis_v_i,
  input  logic        [3*COORD_BITS-1:0] axis_w_i,
  output logic                           done_o,
  output logic                           hit_o
);

  import rost_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;          // origin minus center
  localparam int PW = 2 * CB + 1;      // one coordinate product
  localparam int SW = 2 * CB + 3;      // dot product of three terms
  localparam int WW = 2 * CB + 2;      // cross product component
  localparam int LW = CB + 1;          // low slice of a wide multiplier operand
  localparam int WH = WW - LW;         // high slice of a cross component
  localparam int MH = SW - LW;         // high slice of a projection magnitude
  localparam int LL = CB + LW + 1;     // signed axis times low slice
  localparam int LH = CB + WH;         // signed axis times high slice
  localparam int RL = CB + LW;         // extent times low slice
  localparam int RH = CB + MH;         // extent times high slice
  localparam int XW = 3 * CB + 5;      // cross-term sums
  localparam int EW = CB + FRAC_BITS;  // extent in product scale
  localparam int TW = ((SW > EW) ? SW : EW) + 1;

  // Stage valid bits, index 1 is the first register stage.
  logic [PipeDepth:1] vld_q;

  // Stage 1: operands.
  logic signed [CB-1:0] dir_q  [NumAxes];
  logic signed [DW-1:0] dif_q  [NumAxes];
  logic        [CB-1:0] ext1_q [NumAxes];
  logic signed [CB-1:0] ax1_q  [NumAxes][NumAxes];

  // Stage 2: products.
  logic signed [PW-1:0] pda_q  [NumAxes][NumAxes];
  logic signed [PW-1:0] pfa_q  [NumAxes][NumAxes];
  logic signed [PW-1:0] cpa_q  [NumAxes];
  logic signed [PW-1:0] cpb_q  [NumAxes];
  logic        [CB-1:0] ext2_q [NumAxes];
  logic signed [CB-1:0] ax2_q  [NumAxes][NumAxes];

  // Stage 3: projections and the cross product.
  logic signed [SW-1:0] wdu_q  [NumAxes];
  logic signed [SW-1:0] ddu_q  [NumAxes];
  logic signed [WW-1:0] w3_q   [NumAxes];
  logic        [CB-1:0] ext3_q [NumAxes];
  logic signed [CB-1:0] ax3_q  [NumAxes][NumAxes];

  // Stage 4: slab test result and projection magnitudes.
  logic                 sep4_q;
  logic        [SW-1:0] mag_q  [NumAxes];
  logic signed [WW-1:0] w4_q   [NumAxes];
  logic        [CB-1:0] ext4_q [NumAxes];
  logic signed [CB-1:0] ax4_q  [NumAxes][NumAxes];

  // Stage 5: partial products of the cross-term test.
  logic                 sep5_q;
  logic signed [LL-1:0] llo_q  [NumAxes][NumAxes];
  logic signed [LH-1:0] lhi_q  [NumAxes][NumAxes];
  logic        [RL-1:0] rlo_q  [NumAxes][2];
  logic        [RH-1:0] rhi_q  [NumAxes][2];

  // Stage 6: full products.
  logic                 sep6_q;
  logic signed [XW-1:0] lp_q   [NumAxes][NumAxes];
  logic signed [XW-1:0] rp_q   [NumAxes][2];

  // Stage 7: sums.
  logic                 sep7_q;
  logic signed [XW-1:0] lsum_q [NumAxes];
  logic signed [XW-1:0] rsum_q [NumAxes];

  // Stage 8: result.
  logic                 hit_q;

  logic                 accept;
  logic signed [CB-1:0] dir_in  [NumAxes];
  logic signed [CB-1:0] orig_in [NumAxes];
  logic [NumAxes-1:0]   sep_d;
  logic [NumAxes-1:0]   fit_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign dir_in[0]  = dir_x_i;
  assign dir_in[1]  = dir_y_i;
  assign dir_in[2]  = dir_z_i;
  assign orig_in[0] = orig_x_i;
  assign orig_in[1] = orig_y_i;
  assign orig_in[2] = orig_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-1:1], accept};
    end
  end

  for (genvar i = 0; i < NumAxes; i++) begin : g_axis
    localparam int unsigned J = NextAxis[i];
    localparam int unsigned K = PrevAxis[i];

    logic [SW-1:0] dmag_d;
    logic [TW-1:0] ext_scaled;

    always_ff @(posedge clk_i) begin
      dir_q[i]  <= dir_in[i];
      dif_q[i]  <= DW'(orig_in[i]) - DW'($signed(box_center_i[i*CB +: CB]));
      ext1_q[i] <= half_extents_i[i*CB +: CB];
      ax1_q[0][i] <= $signed(axis_u_i[i*CB +: CB]);
      ax1_q[1][i] <= $signed(axis_v_i[i*CB +: CB]);
      ax1_q[2][i] <= $signed(axis_w_i[i*CB +: CB]);

      cpa_q[i]  <= PW'(dir_q[J]) * PW'(dif_q[K]);
      cpb_q[i]  <= PW'(dir_q[K]) * PW'(dif_q[J]);
      ext2_q[i] <= ext1_q[i];

      wdu_q[i]  <= SW'(pda_q[i][0]) + SW'(pda_q[i][1]) + SW'(pda_q[i][2]);
      ddu_q[i]  <= SW'(pfa_q[i][0]) + SW'(pfa_q[i][1]) + SW'(pfa_q[i][2]);
      w3_q[i]   <= WW'(cpa_q[i]) - WW'(cpb_q[i]);
      ext3_q[i] <= ext2_q[i];

      mag_q[i]  <= wdu_q[i][SW-1] ? SW'(-wdu_q[i]) : SW'(wdu_q[i]);
      w4_q[i]   <= w3_q[i];
      ext4_q[i] <= ext3_q[i];

      // Each bound term is |dir.A| times an extent; split the magnitude in two.
      rlo_q[i][0] <= RL'(ext4_q[J]) * RL'(mag_q[K][LW-1:0]);
      rhi_q[i][0] <= RH'(ext4_q[J]) * RH'(mag_q[K][SW-1:LW]);
      rlo_q[i][1] <= RL'(ext4_q[K]) * RL'(mag_q[J][LW-1:0]);
      rhi_q[i][1] <= RH'(ext4_q[K]) * RH'(mag_q[J][SW-1:LW]);

      rp_q[i][0] <= XW'(XW'(rhi_q[i][0]) << LW) + XW'(rlo_q[i][0]);
      rp_q[i][1] <= XW'(XW'(rhi_q[i][1]) << LW) + XW'(rlo_q[i][1]);

      lsum_q[i] <= lp_q[i][0] + lp_q[i][1] + lp_q[i][2];
      rsum_q[i] <= rp_q[i][0] + rp_q[i][1];
    end

    // The ray leaves through this slab if it starts outside and does not head back.
    assign dmag_d     = ddu_q[i][SW-1] ? SW'(-ddu_q[i]) : SW'(ddu_q[i]);
    assign ext_scaled = TW'({ext3_q[i], {FRAC_BITS{1'b0}}});
    assign sep_d[i]   = (TW'(dmag_d) > ext_scaled)
                        && ((wdu_q[i] == '0) || (ddu_q[i][SW-1] == wdu_q[i][SW-1]));

    assign fit_d[i]   = (lsum_q[i][XW-1] ? -lsum_q[i] : lsum_q[i]) <= rsum_q[i];

    for (genvar j = 0; j < NumAxes; j++) begin : g_term
      always_ff @(posedge clk_i) begin
        ax2_q[i][j] <= ax1_q[i][j];
        ax3_q[i][j] <= ax2_q[i][j];
        ax4_q[i][j] <= ax3_q[i][j];
        pda_q[i][j] <= PW'(dir_q[j]) * PW'(ax1_q[i][j]);
        pfa_q[i][j] <= PW'(dif_q[j]) * PW'(ax1_q[i][j]);
        // W.A uses a cross component wider than one multiplier; split it in two.
        llo_q[i][j] <= LL'(ax4_q[i][j]) * LL'($signed({1'b0, w4_q[j][LW-1:0]}));
        lhi_q[i][j] <= LH'(ax4_q[i][j]) * LH'($signed(w4_q[j][WW-1:LW]));
        lp_q[i][j]  <= (XW'(lhi_q[i][j]) <<< LW) + XW'(llo_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sep4_q <= |sep_d;
    sep5_q <= sep4_q;
    sep6_q <= sep5_q;
    sep7_q <= sep6_q;
    hit_q  <= !sep7_q && (&fit_d);
  end

  assign done_o = vld_q[PipeDepth];
  assign hit_o  = hit_q;

`ifndef NO_ASSERTIONS
  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> ##(PipeDepth - 1) done_o)
    else $error("item lost between the first stage and the result strobe");

  a_sep_misses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && sep4_q) |-> ##4 (done_o && !hit_o))
    else $error("separating slab found but result reports a hit");

  a_bound_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> !(rsum_q[0][XW-1] || rsum_q[1][XW-1] || rsum_q[2][XW-1]))
    else $error("cross-term bound went negative");
`endif

endmodule
